// File: src/assert_macros.svh
// Concurrent assertion helpers; they compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque assertion failed");
`define DEQ_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deque assertion failed");
`else
`define DEQ_ASSERT(label, clk, rst_n, prop)
`define DEQ_ASSERT_NR(label, clk, prop)
`endif

`endif

// File: src/deq_pkg.sv
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_PEEK_FRONT = 3'd4,
        REQ_PEEK_BACK  = 3'd5
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic take_req;
        logic exec;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// File: src/deq_if.sv
interface deq_req_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic        [REQ_W-1:0]  req_type;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   read_value;
    logic        [STATUS_W-1:0] status;

    modport source (output valid, output read_value, output status, input ready);
    modport sink   (input valid, input read_value, input status, output ready);
endinterface

// File: src/deq_datapath.sv
module deq_datapath #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    output deq_pkg::t_dp_sts                    o_sts,
    input  logic        [deq_pkg::REQ_W-1:0]    i_req_type,
    input  logic signed [deq_pkg::DATA_W-1:0]   i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]   o_read_value,
    output logic        [deq_pkg::STATUS_W-1:0] o_status
);
    import deq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];

    t_req              r_req;
    logic [DATA_W-1:0] r_val;
    logic [AW-1:0]     r_front, n_front;
    logic [AW-1:0]     r_back, n_back;
    logic [CW-1:0]     r_occ, n_occ;
    logic              r_rd_ok, n_rd_ok;
    t_status           r_stat, n_stat;
    logic [DATA_W-1:0] r_mem_q;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    t_status           r_out_status;

    logic [AW-1:0] w_addr;
    logic          w_we;
    logic          w_re;
    logic          w_full;
    logic          w_empty;
    logic [AW-1:0] w_front_inc, w_front_dec, w_back_inc, w_back_dec;

    assign w_full  = (r_occ == CW'(DEPTH));
    assign w_empty = (r_occ == '0);

    assign w_front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_back_inc  = (r_back == AW'(DEPTH - 1)) ? '0 : r_back + 1'b1;
    assign w_back_dec  = (r_back == '0) ? AW'(DEPTH - 1) : r_back - 1'b1;

    always_comb begin
        n_front = r_front;
        n_back  = r_back;
        n_occ   = r_occ;
        n_stat  = ST_OK;
        n_rd_ok = 1'b0;
        w_addr  = r_front;
        w_we    = 1'b0;
        w_re    = 1'b0;
        unique case (r_req)
            REQ_PUSH_FRONT: begin
                w_addr = w_front_dec;
                if (w_full) begin
                    n_stat = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_front = w_front_dec;
                    n_occ   = r_occ + 1'b1;
                end
            end
            REQ_PUSH_BACK: begin
                w_addr = r_back;
                if (w_full) begin
                    n_stat = ST_FULL;
                end else begin
                    w_we   = 1'b1;
                    n_back = w_back_inc;
                    n_occ  = r_occ + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                w_addr = r_front;
                if (w_empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    n_rd_ok = 1'b1;
                    n_front = w_front_inc;
                    n_occ   = r_occ - 1'b1;
                end
            end
            REQ_POP_BACK: begin
                w_addr = w_back_dec;
                if (w_empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    n_rd_ok = 1'b1;
                    n_back  = w_back_dec;
                    n_occ   = r_occ - 1'b1;
                end
            end
            REQ_PEEK_FRONT: begin
                w_addr = r_front;
                if (w_empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            REQ_PEEK_BACK: begin
                w_addr = w_back_dec;
                if (w_empty) begin
                    n_stat = ST_EMPTY;
                end else begin
                    w_re    = 1'b1;
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                n_stat = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            mem[w_addr] <= r_val;
        end
        if (i_cmd.exec && w_re) begin
            r_mem_q <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_back      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_occ   <= n_occ;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_req) begin
            r_req <= t_req'(i_req_type);
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_rd_ok <= n_rd_ok;
            r_stat  <= n_stat;
        end
        if (i_cmd.load_out) begin
            // zero unless a pop or peek found something
            r_out_value  <= r_rd_ok ? r_mem_q : '0;
            r_out_status <= r_stat;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_status       = r_out_status;

endmodule

// File: src/deq_ctrl.sv
module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output deq_pkg::t_dp_cmd o_cmd,
    input  deq_pkg::t_dp_sts i_sts
);
    import deq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.take_req = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_req = 1'b1;
                    n_state        = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/double_ended_queue.sv
// A result word passes through the request register, the memory's registered read
//   port and the output register; it waits in S_LOAD while the output is not taken.
// Requests are taken only in S_IDLE, so the block holds one request at a time.
// Reset (synchronous, active low) empties the queue and drops any pending result;
//   the storage itself is not cleared.
`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);
    import deq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_req.ready = w_in_ready;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    deq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_req_type   (i_req.req_type),
        .i_push_value (i_req.push_value),
        .o_out_valid  (o_rsp.valid),
        .i_out_ready  (o_rsp.ready),
        .o_read_value (o_rsp.read_value),
        .o_status     (o_rsp.status)
    );

    `DEQ_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_req.valid && w_in_ready) |=> !w_in_ready)
    `DEQ_ASSERT(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out |-> w_sts.out_free)
    `DEQ_ASSERT(a_exec_follows_take, i_clk, i_rst_n, w_cmd.take_req |=> w_cmd.exec)
    `DEQ_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !o_rsp.valid)

endmodule

// File: verif/double_ended_queue_tb.sv
module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int NUM_DIRECTED   = 20;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int CALM_ITEMS     = 200;
    localparam int PRESSURE_ITEM  = 600;
    localparam int HOLD_OFF_LEN   = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    // request codes the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [STATUS_W-1:0] status;
    } t_deq_result;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [DATA_W-1:0]   value;
        logic                typed;
        logic [DATA_W-1:0]   exp_value;
        logic [STATUS_W-1:0] exp_status;
    } t_stim_row;

    typedef enum {
        RUN_FILL,
        RUN_DRAIN,
        RUN_MIXED,
        RUN_PEEK
    } t_run_mix;

    logic i_clk;
    logic i_rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_PEEK_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_PEEK_BACK,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_UNUSED_A,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_UNUSED_B,   32'h1234_5678, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PUSH_BACK,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PUSH_FRONT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        '{REQ_PEEK_BACK,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_OK},
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_OK},
        // front advances toward the back after a pop
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK},
        '{REQ_PEEK_FRONT, 32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b0, 32'h0000_0000, ST_OK},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK},
        '{REQ_PEEK_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{REQ_PUSH_FRONT, 32'h5555_5555, 1'b0, 32'h0000_0000, ST_OK},
        '{REQ_POP_BACK,   32'hAAAA_AAAA, 1'b0, 32'h0000_0000, ST_OK}
    };

    // queue image kept alongside the block
    logic [DATA_W-1:0] deq_store [DEQ_DEPTH];
    int                head_slot  = 0;
    int                tail_slot  = 0;
    int                fill_count = 0;

    t_deq_result pending_results [$];
    t_deq_result predicted;
    t_deq_result awaited;
    int          error_count = 0;
    int          quiet_cycles = 0;

    // sideband for rows whose result is typed into the table
    logic                row_has_expect = 1'b0;
    logic [DATA_W-1:0]   row_read_value = '0;
    logic [STATUS_W-1:0] row_status     = ST_OK;

    bit          send_bursty    = 1'b0;
    bit          rsp_bursty     = 1'b0;
    bit          calm           = 1'b0;
    int unsigned hold_off_asked = 0;
    int unsigned hold_off_seen  = 0;
    int unsigned rsp_stall_left = 0;

    function automatic t_deq_result deque_apply(input logic [REQ_W-1:0] req,
                                                input logic [DATA_W-1:0] val);
        t_deq_result res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (req)
            REQ_PUSH_FRONT: begin
                if (fill_count >= DEQ_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    head_slot = (head_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    deq_store[head_slot] = val;
                    fill_count++;
                end
            end
            REQ_PUSH_BACK: begin
                if (fill_count >= DEQ_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    deq_store[tail_slot] = val;
                    tail_slot = (tail_slot + 1) % DEQ_DEPTH;
                    fill_count++;
                end
            end
            REQ_POP_FRONT: begin
                if (fill_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.read_value = deq_store[head_slot];
                    head_slot = (head_slot + 1) % DEQ_DEPTH;
                    fill_count--;
                end
            end
            REQ_POP_BACK: begin
                if (fill_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    tail_slot = (tail_slot + DEQ_DEPTH - 1) % DEQ_DEPTH;
                    res.read_value = deq_store[tail_slot];
                    fill_count--;
                end
            end
            REQ_PEEK_FRONT: begin
                if (fill_count == 0) res.status = ST_EMPTY;
                else res.read_value = deq_store[head_slot];
            end
            REQ_PEEK_BACK: begin
                if (fill_count == 0) res.status = ST_EMPTY;
                else res.read_value = deq_store[(tail_slot + DEQ_DEPTH - 1) % DEQ_DEPTH];
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                             input logic typed, input logic [DATA_W-1:0] exp_value,
                             input logic [STATUS_W-1:0] exp_status);
        int gap;
        if (send_bursty && !calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.push_value <= val;
        row_has_expect    <= typed;
        row_read_value    <= exp_value;
        row_status        <= exp_status;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        t_run_mix          mix;
        int                run_len;
        int                item;
        int                k;
        int                roll;
        int                push_pct;
        int                peek_pct;
        logic [REQ_W-1:0]  req;
        logic [DATA_W-1:0] val;

        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_PUSH_FRONT;
        req_ch.push_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_bursty = 1'b1;
        rsp_bursty  <= 1'b1;
        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].req, directed_rows[r].value, directed_rows[r].typed,
                      directed_rows[r].exp_value, directed_rows[r].exp_status);
        end

        item = 0;
        while (item < RANDOM_ITEMS) begin
            mix         = t_run_mix'($urandom_range(0, 3));
            run_len     = $urandom_range(15, 60);
            send_bursty = ($urandom_range(0, 2) != 0);
            rsp_bursty  <= ($urandom_range(0, 2) != 0);
            case (mix)
                RUN_FILL:  begin push_pct = 85; peek_pct = 5;  end
                RUN_DRAIN: begin push_pct = 12; peek_pct = 8;  end
                RUN_MIXED: begin push_pct = 45; peek_pct = 15; end
                default:   begin push_pct = 45; peek_pct = 35; end
            endcase
            for (k = 0; k < run_len && item < RANDOM_ITEMS; k++) begin
                if (item == PRESSURE_ITEM) begin
                    // stall the result side long enough to back up the request side
                    hold_off_asked <= hold_off_asked + 1;
                end
                if (item == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    req = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
                else if (roll < push_pct)
                    req = ($urandom_range(0, 1) != 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                else if (roll < push_pct + peek_pct)
                    req = ($urandom_range(0, 1) != 0) ? REQ_PEEK_FRONT : REQ_PEEK_BACK;
                else
                    req = ($urandom_range(0, 1) != 0) ? REQ_POP_FRONT : REQ_POP_BACK;
                case ($urandom_range(0, 9))
                    0:       val = 32'h8000_0000;
                    1:       val = 32'h7FFF_FFFF;
                    2:       val = 32'hFFFF_FFFF;
                    3:       val = 32'h0000_0000;
                    default: val = $urandom;
                endcase
                send_word(req, val, 1'b0, '0, ST_OK);
                item++;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                if (hold_off_seen != hold_off_asked) begin
                    hold_off_seen  = hold_off_asked;
                    rsp_stall_left = HOLD_OFF_LEN;
                end else if (rsp_stall_left == 0 && rsp_bursty && !calm
                             && $urandom_range(0, 5) == 0) begin
                    rsp_stall_left = $urandom_range(1, 9);
                end
                if (rsp_stall_left > 0) begin
                    rsp_stall_left--;
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                predicted = deque_apply(req_ch.req_type, req_ch.push_value);
                if (row_has_expect) begin
                    predicted.read_value = row_read_value;
                    predicted.status     = row_status;
                end
                pending_results.insert(pending_results.size(), predicted);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result word with no request pending");
                end else begin
                    awaited = pending_results[0];
                    pending_results.delete(0);
                    if (rsp_ch.read_value !== awaited.read_value)
                        flag_mismatch($sformatf("read_value got %h want %h",
                                                rsp_ch.read_value, awaited.read_value));
                    if (rsp_ch.status !== awaited.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                rsp_ch.status, awaited.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule

// File: filelist.f
+incdir+src
src/deq_pkg.sv
src/deq_if.sv
src/deq_datapath.sv
src/deq_ctrl.sv
src/double_ended_queue.sv
verif/double_ended_queue_tb.sv
